// ===== design/single_wire_sensor_frame_receiver_defines.svh =====
// -----------------------------------------------------------------------------
// Single-wire sensor frame receiver: assertion macros
// Shared property forms for the port-level checker.
// -----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_SENSOR_FRAME_RECEIVER_DEFINES_SVH
`define SINGLE_WIRE_SENSOR_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication
`define SWSFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SWSFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/swsfr_pkg.sv =====
// -----------------------------------------------------------------------------
// Single-wire sensor frame receiver package
// Phase encoding, status codes, register map and reset values.
// -----------------------------------------------------------------------------
package swsfr_pkg;

    localparam int FRAME_BYTES   = 5;
    localparam int PULSE_ENTRIES = 80;
    localparam int FRAME_BITS    = FRAME_BYTES * 8;
    localparam int BIT_TOTAL     = PULSE_ENTRIES / 2;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_PRE      = 4'd1,
        PH_STARTLOW = 4'd2,
        PH_RELEASE  = 4'd3,
        PH_SETTLE   = 4'd4,
        PH_ACKL     = 4'd5,
        PH_ACKH     = 4'd6,
        PH_BITL     = 4'd7,
        PH_BITH     = 4'd8
    } phase_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CHECKSUM = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;

    localparam logic [2:0] REG_PRE_HIGH     = 3'd0;
    localparam logic [2:0] REG_START_LOW    = 3'd1;
    localparam logic [2:0] REG_RELEASE_HIGH = 3'd2;
    localparam logic [2:0] REG_SETTLE       = 3'd3;
    localparam logic [2:0] REG_PULSE_TMO    = 3'd4;
    localparam logic [2:0] REG_MIN_INTERVAL = 3'd5;

    localparam logic [19:0] RST_PRE_HIGH     = 20'd250000;
    localparam logic [19:0] RST_START_LOW    = 20'd20000;
    localparam logic [9:0]  RST_RELEASE_HIGH = 10'd40;
    localparam logic [9:0]  RST_SETTLE       = 10'd10;
    localparam logic [15:0] RST_PULSE_TMO    = 16'd1000;
    localparam logic [31:0] RST_MIN_INTERVAL = 32'd2000000;

    // skip timed phases of zero length; zero[0..3] flag PRE..SETTLE
    function automatic phase_t skip_zero(phase_t p, logic [3:0] zero);
        phase_t q;
        q = p;
        if (q == PH_PRE      && zero[0]) q = PH_STARTLOW;
        if (q == PH_STARTLOW && zero[1]) q = PH_RELEASE;
        if (q == PH_RELEASE  && zero[2]) q = PH_SETTLE;
        if (q == PH_SETTLE   && zero[3]) q = PH_ACKL;
        return q;
    endfunction

endpackage

// ===== design/single_wire_sensor_frame_receiver.sv =====
// -----------------------------------------------------------------------------
// Single-wire sensor frame receiver
// Each accepted sample word gives one result word, held in the output register.
// Throughput: one sample word per cycle unless stalled; output drains while loading.
// Reset: synchronous, active low; phase idle, interval counter saturated, registers default.
// -----------------------------------------------------------------------------
module single_wire_sensor_frame_receiver
    import swsfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // line_level, start_request, force_req, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // drive_enable, drive_level, busy_res, done_res,
                                   // status[1:0], frame_data[39:0], pad
    output logic        m_tuser,   // from_cache
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [19:0] pre_high_reg;
    logic [19:0] start_low_reg;
    logic [9:0]  release_high_reg;
    logic [9:0]  settle_reg;
    logic [15:0] pulse_tmo_reg;
    logic [31:0] min_interval_reg;

    phase_t                 phase_reg, phase_next, run_phase;
    logic [19:0]            phase_ticks_reg, phase_ticks_next;
    logic [15:0]            low_count_reg, low_count_next;
    logic [15:0]            pulse_count_reg, pulse_count_next;
    logic [5:0]             bit_index_reg, bit_index_next;
    logic [FRAME_BITS-1:0]  frame_reg, frame_next;
    logic [31:0]            since_reg, since_next;
    logic [1:0]             last_status_reg, last_status_next;

    logic        accept;
    logic        line_level, start_request, force_req;
    logic        cache_hit, fail, finish;
    logic [3:0]  zero_len;
    logic [19:0] cur_len;
    logic        expect_level;
    logic [7:0]  csum;

    logic        drive_enable, drive_level, busy_res, done_res, from_cache;
    logic [1:0]  status;
    logic [FRAME_BITS-1:0] frame_data;

    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign line_level    = s_tdata[0];
    assign start_request = s_tdata[1];
    assign force_req     = s_tdata[2];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign zero_len = {settle_reg == 10'd0, release_high_reg == 10'd0,
                       start_low_reg == 20'd0, pre_high_reg == 20'd0};

    // next state
    always_comb begin
        phase_next       = phase_reg;
        phase_ticks_next = phase_ticks_reg;
        low_count_next   = low_count_reg;
        pulse_count_next = pulse_count_reg;
        bit_index_next   = bit_index_reg;
        frame_next       = frame_reg;
        since_next       = since_reg;
        last_status_next = last_status_reg;
        cache_hit        = 1'b0;
        fail             = 1'b0;
        finish           = 1'b0;
        cur_len          = 20'd0;
        expect_level     = 1'b0;
        csum             = 8'd0;

        if (phase_reg == PH_IDLE && start_request) begin
            if (!force_req && since_reg < min_interval_reg) begin
                cache_hit = 1'b1;
            end else begin
                frame_next       = '0;
                since_next       = 32'd0;
                phase_next       = skip_zero(PH_PRE, zero_len);
                phase_ticks_next = 20'd0;
                pulse_count_next = 16'd0;
                if (phase_next == PH_ACKL) bit_index_next = 6'd0;
            end
        end
        run_phase = phase_next;

        if (phase_next inside {PH_PRE, PH_STARTLOW, PH_RELEASE, PH_SETTLE}) begin
            case (phase_next)
                PH_PRE:      cur_len = pre_high_reg;
                PH_STARTLOW: cur_len = start_low_reg;
                PH_RELEASE:  cur_len = {10'd0, release_high_reg};
                default:     cur_len = {10'd0, settle_reg};
            endcase
            phase_ticks_next = phase_ticks_next + 20'd1;
            if (phase_ticks_next >= cur_len) begin
                phase_next       = skip_zero(phase_t'(phase_next + 4'd1), zero_len);
                phase_ticks_next = 20'd0;
                pulse_count_next = 16'd0;
                if (phase_next == PH_ACKL) bit_index_next = 6'd0;
            end
        end else if (phase_next != PH_IDLE) begin
            expect_level = (phase_next == PH_ACKH) || (phase_next == PH_BITH);
            if (line_level == expect_level) begin
                if (pulse_count_next >= pulse_tmo_reg) fail = 1'b1;
                else pulse_count_next = pulse_count_next + 16'd1;
            end else if (pulse_count_next == 16'd0) begin
                fail = 1'b1;
            end else begin
                if (phase_next == PH_BITH) begin
                    frame_next = {frame_next[FRAME_BITS-2:0],
                                  pulse_count_next > low_count_next};
                    bit_index_next = bit_index_next + 6'd1;
                    finish = (bit_index_next >= 6'(BIT_TOTAL));
                end else if (phase_next == PH_BITL) begin
                    low_count_next = pulse_count_next;
                end
                if (!finish) begin
                    case (phase_next)
                        PH_BITH: phase_next = PH_BITL;
                        PH_BITL: phase_next = PH_BITH;
                        default: phase_next = phase_t'(phase_next + 4'd1);
                    endcase
                    if (pulse_tmo_reg == 16'd0) fail = 1'b1;
                    else pulse_count_next = 16'd1;
                end
            end
        end

        if (fail) begin
            phase_next       = PH_IDLE;
            frame_next       = '0;
            last_status_next = ST_TIMEOUT;
        end else if (finish) begin
            csum = frame_next[39:32] + frame_next[31:24] + frame_next[23:16]
                 + frame_next[15:8];
            last_status_next = (csum == frame_next[7:0]) ? ST_OK : ST_CHECKSUM;
            phase_next       = PH_IDLE;
        end

        if (since_next != 32'hFFFF_FFFF) since_next = since_next + 32'd1;
    end

    // result word
    always_comb begin
        drive_enable = run_phase inside {PH_PRE, PH_STARTLOW, PH_RELEASE};
        drive_level  = run_phase inside {PH_PRE, PH_RELEASE};
        busy_res     = (run_phase != PH_IDLE) && !fail && !finish;
        done_res     = cache_hit || fail || finish;
        from_cache   = cache_hit;
        if (fail) begin
            status     = ST_TIMEOUT;
            frame_data = '0;
        end else if (finish) begin
            status     = last_status_next;
            frame_data = frame_next;
        end else if (cache_hit) begin
            status     = last_status_reg;
            frame_data = frame_reg;
        end else begin
            status     = ST_OK;
            frame_data = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            phase_ticks_reg <= 20'd0;
            low_count_reg   <= 16'd0;
            pulse_count_reg <= 16'd0;
            bit_index_reg   <= 6'd0;
            frame_reg       <= '0;
            since_reg       <= 32'hFFFF_FFFF;
            last_status_reg <= ST_OK;
        end else if (accept) begin
            phase_reg       <= phase_next;
            phase_ticks_reg <= phase_ticks_next;
            low_count_reg   <= low_count_next;
            pulse_count_reg <= pulse_count_next;
            bit_index_reg   <= bit_index_next;
            frame_reg       <= frame_next;
            since_reg       <= since_next;
            last_status_reg <= last_status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {2'b00, frame_data, status, done_res, busy_res,
                            drive_level, drive_enable};
            m_tuser_reg <= from_cache;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_high_reg     <= RST_PRE_HIGH;
            start_low_reg    <= RST_START_LOW;
            release_high_reg <= RST_RELEASE_HIGH;
            settle_reg       <= RST_SETTLE;
            pulse_tmo_reg    <= RST_PULSE_TMO;
            min_interval_reg <= RST_MIN_INTERVAL;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PRE_HIGH:     pre_high_reg     <= pwdata[19:0];
                REG_START_LOW:    start_low_reg    <= pwdata[19:0];
                REG_RELEASE_HIGH: release_high_reg <= pwdata[9:0];
                REG_SETTLE:       settle_reg       <= pwdata[9:0];
                REG_PULSE_TMO:    pulse_tmo_reg    <= pwdata[15:0];
                REG_MIN_INTERVAL: min_interval_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PRE_HIGH:     prdata = {12'd0, pre_high_reg};
            REG_START_LOW:    prdata = {12'd0, start_low_reg};
            REG_RELEASE_HIGH: prdata = {22'd0, release_high_reg};
            REG_SETTLE:       prdata = {22'd0, settle_reg};
            REG_PULSE_TMO:    prdata = {16'd0, pulse_tmo_reg};
            REG_MIN_INTERVAL: prdata = min_interval_reg;
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// ===== design/swsfr_checker.sv =====
// -----------------------------------------------------------------------------
// Single-wire sensor frame receiver port checker
// Watches the result channel for consistent result words and input readiness.
// -----------------------------------------------------------------------------
`include "single_wire_sensor_frame_receiver_defines.svh"

module swsfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    `SWSFR_ASSERT_NEXT(a_hold_word, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed under stall")

    `SWSFR_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output register")

    `SWSFR_ASSERT_NOW(a_busy_done_excl, m_tvalid, !(m_tdata[2] && m_tdata[3]), "busy and done in one word")

    `SWSFR_ASSERT_NOW(a_quiet_when_not_done, m_tvalid && !m_tdata[3], (m_tdata[5:4] == 2'd0) && (m_tdata[45:6] == 40'd0) && !m_tuser, "status or data without done")

    `SWSFR_ASSERT_NOW(a_cache_idle, m_tvalid && m_tuser, m_tdata[3] && !m_tdata[2] && !m_tdata[0], "cached answer while driving or busy")

endmodule

bind single_wire_sensor_frame_receiver swsfr_checker u_swsfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== verif/tb_single_wire_sensor_frame_receiver.sv =====
// -----------------------------------------------------------------------------
// Single-wire sensor frame receiver testbench
// Streams 1 us line samples into the receiver and checks every result word
// against a cycle-free behavioural predictor. Sensor replies are built as
// acknowledge and bit pulse trains with random widths and payloads, plus
// zero-length and overlong pulses, bad checksums, cached answers and
// requests while busy. Timing registers are changed over APB between
// phases, with read-back. Both stream sides stall at random, and the
// result sink holds off once for a long stretch to fill the block.
// -----------------------------------------------------------------------------
module tb_single_wire_sensor_frame_receiver;
    import swsfr_pkg::*;

    typedef struct packed {
        logic frc;
        logic req;
        logic line;
    } sample_t;

    typedef struct packed {
        logic        cache;
        logic [39:0] data;
        logic [1:0]  st;
        logic        done;
        logic        busy;
        logic        dl;
        logic        de;
    } sensor_word_t;

    typedef enum int {FAULT_NONE, FAULT_ZERO, FAULT_LONG} frame_fault_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    single_wire_sensor_frame_receiver u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // timing registers as last written
    logic [19:0] cfg_pre     = RST_PRE_HIGH;
    logic [19:0] cfg_low     = RST_START_LOW;
    logic [9:0]  cfg_rel     = RST_RELEASE_HIGH;
    logic [9:0]  cfg_settle  = RST_SETTLE;
    logic [15:0] cfg_tmo     = RST_PULSE_TMO;
    logic [31:0] cfg_gap     = RST_MIN_INTERVAL;

    // receiver state
    phase_t      rd_phase    = PH_IDLE;
    logic [19:0] rd_ticks    = '0;
    logic [15:0] low_width   = '0;
    logic [15:0] pulse_width = '0;
    logic [5:0]  bits_taken  = '0;
    logic [39:0] shift_reg   = '0;
    logic [31:0] since_read  = '1;
    logic [1:0]  prev_status = ST_OK;

    sample_t      sample_q[$];
    sensor_word_t predicted_words[$];
    logic         line_plan[$];
    int           plan_idx;
    int           plan_cut;
    bit           plan_stop;

    int  fault_count;
    int  n_pushed;
    int  n_checked;
    int  n_good, n_badsum, n_abort, n_cached;
    int  n_settings;
    int  src_idle_pct, snk_idle_pct;
    int  src_gap, snk_gap, hold_left;
    int  stall_asks, stall_seen;
    bit  in_taken;

    function automatic logic [19:0] timed_len(phase_t p);
        case (p)
            PH_PRE:      return cfg_pre;
            PH_STARTLOW: return cfg_low;
            PH_RELEASE:  return {10'd0, cfg_rel};
            default:     return {10'd0, cfg_settle};
        endcase
    endfunction

    function automatic void enter_timed(phase_t p);
        while (p >= PH_PRE && p <= PH_SETTLE && timed_len(p) == 20'd0)
            p = phase_t'(p + 1);
        rd_phase    = p;
        rd_ticks    = '0;
        pulse_width = '0;
        if (p == PH_ACKL)
            bits_taken = '0;
    endfunction

    function automatic sensor_word_t next_receiver_word(logic line, logic req, logic frc);
        sensor_word_t w;
        logic         fail;
        logic         finish;
        logic         want;
        logic [7:0]   sum;
        phase_t       nxt;
        w      = '0;
        fail   = 1'b0;
        finish = 1'b0;
        if (rd_phase == PH_IDLE && req) begin
            if (!frc && since_read < cfg_gap) begin
                w.done  = 1'b1;
                w.st    = prev_status;
                w.cache = 1'b1;
                w.data  = shift_reg;
            end else begin
                shift_reg  = '0;
                since_read = '0;
                enter_timed(PH_PRE);
            end
        end
        if (rd_phase != PH_IDLE) begin
            w.busy = 1'b1;
            if (rd_phase <= PH_SETTLE) begin
                if (rd_phase == PH_PRE || rd_phase == PH_RELEASE) begin
                    w.de = 1'b1;
                    w.dl = 1'b1;
                end else if (rd_phase == PH_STARTLOW) begin
                    w.de = 1'b1;
                end
                rd_ticks++;
                if (rd_ticks >= timed_len(rd_phase))
                    enter_timed(phase_t'(rd_phase + 1));
            end else begin
                want = (rd_phase == PH_ACKH || rd_phase == PH_BITH);
                if (line == want) begin
                    if (pulse_width >= cfg_tmo)
                        fail = 1'b1;
                    else
                        pulse_width++;
                end else if (pulse_width == '0) begin
                    fail = 1'b1;
                end else begin
                    nxt = phase_t'(rd_phase + 1);
                    if (rd_phase == PH_BITH) begin
                        shift_reg = {shift_reg[38:0], pulse_width > low_width};
                        bits_taken++;
                        finish = (bits_taken >= BIT_TOTAL);
                        nxt    = PH_BITL;
                    end else if (rd_phase == PH_BITL) begin
                        low_width = pulse_width;
                    end
                    if (!finish) begin
                        rd_phase = nxt;
                        if (cfg_tmo == '0)
                            fail = 1'b1;
                        else
                            pulse_width = 16'd1;
                    end
                end
            end
        end
        if (fail) begin
            rd_phase    = PH_IDLE;
            shift_reg   = '0;
            prev_status = ST_TIMEOUT;
            w.busy      = 1'b0;
            w.done      = 1'b1;
            w.st        = ST_TIMEOUT;
            w.data      = '0;
        end else if (finish) begin
            sum = shift_reg[39:32] + shift_reg[31:24] + shift_reg[23:16] + shift_reg[15:8];
            prev_status = (sum == shift_reg[7:0]) ? ST_OK : ST_CHECKSUM;
            rd_phase    = PH_IDLE;
            w.busy      = 1'b0;
            w.done      = 1'b1;
            w.st        = prev_status;
            w.data      = shift_reg;
        end
        if (since_read != '1)
            since_read++;
        return w;
    endfunction

    task automatic note_fault(string msg);
        if (fault_count < 10)
            $display("%t: %s", $time, msg);
        fault_count++;
    endtask

    // accept result words, then sample words
    always @(posedge aclk) begin
        sensor_word_t got;
        sensor_word_t exp_w;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[45:0]};
                if (predicted_words.size() == 0) begin
                    note_fault("result word with nothing outstanding");
                end else begin
                    exp_w = predicted_words.pop_front();
                    if (got.de !== exp_w.de || got.dl !== exp_w.dl ||
                        got.busy !== exp_w.busy || got.done !== exp_w.done ||
                        got.st !== exp_w.st || got.cache !== exp_w.cache ||
                        got.data !== exp_w.data)
                        note_fault($sformatf({"word %0d mismatch: exp de=%b dl=%b busy=%b ",
                            "done=%b st=%0d cache=%b data=%h, got de=%b dl=%b busy=%b ",
                            "done=%b st=%0d cache=%b data=%h"}, n_checked,
                            exp_w.de, exp_w.dl, exp_w.busy, exp_w.done, exp_w.st,
                            exp_w.cache, exp_w.data, got.de, got.dl, got.busy, got.done,
                            got.st, got.cache, got.data));
                    n_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                exp_w = next_receiver_word(s_tdata[0], s_tdata[1], s_tdata[2]);
                predicted_words.push_back(exp_w);
                if (exp_w.done) begin
                    if (exp_w.cache)
                        n_cached++;
                    else if (exp_w.st == ST_OK)
                        n_good++;
                    else if (exp_w.st == ST_CHECKSUM)
                        n_badsum++;
                    else
                        n_abort++;
                end
            end
            in_taken = s_tvalid && s_tready;
        end else begin
            in_taken = 1'b0;
        end
    end

    // sample word source
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (sample_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if ($urandom_range(0, 99) < src_idle_pct) begin
                src_gap = $urandom_range(0, 3);
                s_tvalid <= 1'b0;
            end else begin
                s_tdata  <= {5'd0, sample_q.pop_front()};
                s_tvalid <= 1'b1;
            end
        end
    end

    // result word sink
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_seen != stall_asks) begin
            stall_seen = stall_asks;
            hold_left  = 150;
            m_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < snk_idle_pct) begin
            snk_gap = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        logic [31:0] want;
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        case (idx)
            REG_PRE_HIGH:     cfg_pre    = val[19:0];
            REG_START_LOW:    cfg_low    = val[19:0];
            REG_RELEASE_HIGH: cfg_rel    = val[9:0];
            REG_SETTLE:       cfg_settle = val[9:0];
            REG_PULSE_TMO:    cfg_tmo    = val[15:0];
            default:          cfg_gap    = val;
        endcase
        case (idx)
            REG_PRE_HIGH, REG_START_LOW:    want = {12'd0, val[19:0]};
            REG_RELEASE_HIGH, REG_SETTLE:   want = {22'd0, val[9:0]};
            REG_PULSE_TMO:                  want = {16'd0, val[15:0]};
            default:                        want = val;
        endcase
        @(negedge aclk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (prdata !== want)
            note_fault($sformatf("register %0d reads %h, expected %h", idx, prdata, want));
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_timing(int pre, int low, int rel, int settle, int tmo,
                              logic [31:0] gap);
        cfg_write(REG_PRE_HIGH, pre);
        cfg_write(REG_START_LOW, low);
        cfg_write(REG_RELEASE_HIGH, rel);
        cfg_write(REG_SETTLE, settle);
        cfg_write(REG_PULSE_TMO, tmo);
        cfg_write(REG_MIN_INTERVAL, gap);
        n_settings++;
    endtask

    task automatic push_sample(logic line, logic req, logic frc);
        sample_q.push_back('{frc: frc, req: req, line: line});
        n_pushed++;
    endtask

    function automatic logic [39:0] sensor_frame(logic [31:0] body, logic good);
        logic [7:0] sum;
        sum = body[31:24] + body[23:16] + body[15:8] + body[7:0];
        if (!good)
            sum = sum + 8'($urandom_range(1, 255));
        return {body, sum};
    endfunction

    task automatic add_pulse(logic lvl, int width);
        int n;
        if (!plan_stop) begin
            if (plan_idx == plan_cut) begin
                width     = int'(cfg_tmo) + 1;
                plan_stop = 1'b1;
            end
            plan_idx++;
            for (n = 0; n < width; n++)
                line_plan.push_back(lvl);
        end
    endtask

    // request, start sequence, then the sensor's acknowledge and 40 bit pulses
    task automatic push_read(logic frc, logic [39:0] frame, frame_fault_t fault,
                             int wmax, bit busy_reqs);
        int cap, j, lo, hi, start_len, n;
        line_plan.delete();
        plan_idx  = 0;
        plan_stop = 1'b0;
        cap = (int'(cfg_tmo) < wmax) ? int'(cfg_tmo) : wmax;
        if (cap < 1)
            cap = 1;
        plan_cut = (fault == FAULT_LONG) ? $urandom_range(0, 81) : -1;
        if (fault == FAULT_ZERO) begin
            line_plan.push_back(1'b1);
        end else begin
            add_pulse(1'b0, $urandom_range(1, cap));
            add_pulse(1'b1, $urandom_range(1, cap));
            for (j = 0; j < BIT_TOTAL; j++) begin
                if (frame[39 - j] && cap >= 2) begin
                    lo = $urandom_range(1, cap - 1);
                    hi = $urandom_range(lo + 1, cap);
                end else begin
                    hi = $urandom_range(1, cap);
                    lo = $urandom_range(hi, cap);
                end
                add_pulse(1'b0, lo);
                add_pulse(1'b1, hi);
            end
            if (!plan_stop)
                line_plan.push_back(1'b0);
        end
        start_len = int'(cfg_pre) + int'(cfg_low) + int'(cfg_rel) + int'(cfg_settle);
        if (start_len == 0) begin
            push_sample(line_plan.pop_front(), 1'b1, frc);
        end else begin
            push_sample($urandom_range(0, 1), 1'b1, frc);
            for (n = 1; n < start_len; n++)
                push_sample($urandom_range(0, 1), busy_reqs && $urandom_range(0, 7) == 0,
                            $urandom_range(0, 1));
        end
        while (line_plan.size() != 0)
            push_sample(line_plan.pop_front(), busy_reqs && $urandom_range(0, 15) == 0,
                        $urandom_range(0, 1));
    endtask

    // drain, then drop any read still in progress by holding the line high
    task automatic settle_down();
        do begin
            while (sample_q.size() != 0 || predicted_words.size() != 0 || s_tvalid)
                @(posedge aclk);
            repeat (4) @(posedge aclk);
            if (rd_phase != PH_IDLE)
                repeat (16) push_sample(1'b1, 1'b0, 1'b0);
        end while (sample_q.size() != 0);
    endtask

    initial begin
        #(12 * 900000);
        $display("[single_wire_sensor_frame_receiver] ERROR");
        $finish;
    end

    initial begin
        int   round, mark, pick;
        logic frc;
        frame_fault_t fault;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        src_idle_pct = 20;
        snk_idle_pct = 20;
        set_timing(2, 3, 1, 2, 6, 2000);
        push_read(1'b0, sensor_frame(32'h0, 1'b1), FAULT_NONE, 3, 1'b0);
        push_sample(1'b1, 1'b1, 1'b0);
        push_read(1'b1, sensor_frame(32'hFFFF_FFFF, 1'b1), FAULT_NONE, 3, 1'b0);
        push_read(1'b1, sensor_frame(32'hFFFF_FFFF, 1'b0), FAULT_NONE, 3, 1'b0);
        push_sample(1'b0, 1'b1, 1'b0);
        push_read(1'b1, sensor_frame(32'hA55A_3CC3, 1'b1), FAULT_ZERO, 4, 1'b0);
        push_sample(1'b1, 1'b1, 1'b0);
        push_read(1'b1, sensor_frame($urandom, 1'b1), FAULT_LONG, 4, 1'b0);
        push_read(1'b1, sensor_frame($urandom, 1'b1), FAULT_NONE, 3, 1'b1);
        settle_down();

        // shortest start sequence and one-sample pulses
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_timing(0, 1, 0, 0, 1, 0);
        push_read(1'b0, sensor_frame($urandom, 1'b1), FAULT_NONE, 1, 1'b0);
        push_read(1'b1, sensor_frame($urandom, 1'b0), FAULT_LONG, 1, 1'b0);
        push_read(1'b0, sensor_frame($urandom, 1'b1), FAULT_ZERO, 1, 1'b0);
        push_read(1'b0, sensor_frame($urandom, 1'b1), FAULT_NONE, 1, 1'b0);
        settle_down();

        // no start sequence at all, zero timeout fails every pulse sample
        set_timing(0, 0, 0, 0, 0, 0);
        repeat (6) begin
            push_sample($urandom_range(0, 1), 1'b1, $urandom_range(0, 1));
            push_sample($urandom_range(0, 1), 1'b0, $urandom_range(0, 1));
        end
        settle_down();
        cfg_write(REG_PULSE_TMO, 3);
        push_read(1'b0, sensor_frame($urandom, 1'b1), FAULT_NONE, 3, 1'b0);
        push_read(1'b1, sensor_frame($urandom, 1'b1), FAULT_ZERO, 3, 1'b0);
        push_read(1'b0, sensor_frame($urandom, 1'b1), FAULT_LONG, 3, 1'b0);
        push_read(1'b1, sensor_frame($urandom, 1'b0), FAULT_NONE, 3, 1'b1);
        settle_down();

        // largest values; every request is answered from the cache
        src_idle_pct = 30;
        snk_idle_pct = 30;
        set_timing(20'hF_FFFF, 20'hF_FFFF, 1023, 1023, 65535, 32'hFFFF_FFFF);
        repeat (30)
            push_sample($urandom_range(0, 1), $urandom_range(0, 2) == 0, 1'b0);
        settle_down();

        // long release and settle, never cached
        src_idle_pct = 10;
        snk_idle_pct = 10;
        set_timing(4, 4, 32, 32, 65535, 0);
        push_read(1'b0, sensor_frame($urandom, 1'b1), FAULT_NONE, 3, 1'b0);
        push_read(1'b1, sensor_frame($urandom, 1'b0), FAULT_NONE, 3, 1'b1);
        settle_down();

        for (round = 0; round < 4; round++) begin
            src_idle_pct = (round == 3) ? 0 : $urandom_range(5, 30);
            snk_idle_pct = (round == 3) ? 0 : $urandom_range(5, 30);
            set_timing($urandom_range(0, 3), $urandom_range(1, 3), $urandom_range(0, 2),
                       $urandom_range(0, 2), $urandom_range(2, 8),
                       $urandom_range(100, 800));
            mark = n_pushed;
            while (n_pushed - mark < 60) begin
                pick = $urandom_range(0, 99);
                if (pick < 72) begin
                    frc   = ($urandom_range(0, 4) != 0);
                    pick  = $urandom_range(0, 99);
                    fault = (pick < 8) ? FAULT_ZERO : (pick < 16) ? FAULT_LONG : FAULT_NONE;
                    push_read(frc, sensor_frame($urandom, $urandom_range(0, 5) != 0), fault,
                              $urandom_range(2, 5), frc && $urandom_range(0, 3) == 0);
                end else if (pick < 86) begin
                    repeat ($urandom_range(1, 8))
                        push_sample($urandom_range(0, 1), 1'b0, $urandom_range(0, 1));
                end else begin
                    push_sample($urandom_range(0, 1), 1'b1, $urandom_range(0, 1));
                end
            end
            if (round == 1)
                stall_asks++;
            settle_down();
        end

        repeat (8) @(posedge aclk);
        if (predicted_words.size() != 0)
            note_fault($sformatf("%0d result words never arrived", predicted_words.size()));
        $display("covered %0d sample words over %0d register settings, one long hold-off",
                 n_checked, n_settings);
        $display("reads: %0d good, %0d checksum faults, %0d aborted, %0d cached answers",
                 n_good, n_badsum, n_abort, n_cached);
        if (fault_count == 0)
            $display("[single_wire_sensor_frame_receiver] OK");
        else
            $display("[single_wire_sensor_frame_receiver] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/swsfr_pkg.sv
design/single_wire_sensor_frame_receiver.sv
design/swsfr_checker.sv
verif/tb_single_wire_sensor_frame_receiver.sv
